[rtl/tmps_pkg.sv]
// Shared types and constants for the triangle maximum path sum block.
`default_nettype none

package tmps_pkg;

  // Largest number of rows a triangle may have before it is rejected.
  localparam int MAX_ROWS = 128;

  localparam int VALUE_W  = 16;
  localparam int SUM_W    = 24;
  localparam int STATUS_W = 2;

  // The row counter must hold MAX_ROWS itself; a column stays below MAX_ROWS.
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int COL_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RAGGED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd2;

  // Queue between the front and back parts.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // One classified element as handed from the front part to the back part.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic [COL_W-1:0]   col;
    logic               first;     // column zero: no left parent
    logic               has_up;    // column below row: the entry above is valid
    logic               row_done;  // column equals row: this element closes the row
    logic               over;      // triangle has run past MAX_ROWS rows
  } tmps_item_t;

endpackage

`default_nettype wire

[rtl/tmps_front.sv]
// Front part: accepts elements, tracks row and column, and classifies each beat.
`default_nettype none

module tmps_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [tmps_pkg::VALUE_W-1:0]  in_value,
  input  wire logic                          in_last,
  output      logic                          push,
  input  wire logic                          push_ready,
  output      tmps_pkg::tmps_item_t          push_item
);
  import tmps_pkg::*;

  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] column_index;
  logic             overflowed;

  logic             accept;
  logic             over_now;
  logic [ROW_W-1:0] col_wide;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign over_now = overflowed || (row_index >= ROW_W'(MAX_ROWS));
  assign col_wide = ROW_W'(column_index);

  // Elements past the row limit are dropped unless they close the triangle.
  assign push = accept && (!over_now || in_last);

  always_comb begin
    push_item.value    = in_value;
    push_item.last     = in_last;
    push_item.col      = column_index;
    push_item.first    = (column_index == '0);
    push_item.has_up   = (col_wide < row_index);
    push_item.row_done = (col_wide == row_index);
    push_item.over     = over_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index    <= '0;
      column_index <= '0;
      overflowed   <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        row_index    <= '0;
        column_index <= '0;
        overflowed   <= 1'b0;
      end else if (over_now) begin
        overflowed <= 1'b1;
      end else if (col_wide == row_index) begin
        row_index    <= row_index + 1'b1;
        column_index <= '0;
      end else begin
        column_index <= column_index + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tmps_queue.sv]
// Two-entry register queue between the front and back parts.
`default_nettype none

module tmps_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output      logic                  push_ready,
  input  wire tmps_pkg::tmps_item_t  push_item,
  output      logic                  head_valid,
  input  wire logic                  pop,
  output      tmps_pkg::tmps_item_t  head_item
);
  import tmps_pkg::*;

  tmps_item_t         entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_CNT_W-1:0] count;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tmps_back.sv]
// Back part: row buffer, path sum update, row maximum and result register.
`default_nettype none

module tmps_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           head_valid,
  input  wire tmps_pkg::tmps_item_t           head_item,
  output      logic                           pop,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [tmps_pkg::SUM_W-1:0]     out_sum,
  output      logic [tmps_pkg::STATUS_W-1:0]  out_status
);
  import tmps_pkg::*;

  logic [SUM_W-1:0] best_row [MAX_ROWS];

  // Execute stage.
  logic             ex_valid;
  tmps_item_t       ex_item;
  logic [SUM_W-1:0] rd_data;

  logic [SUM_W-1:0] left_parent;
  logic [SUM_W-1:0] row_maximum;

  logic              out_free;
  logic              ex_fire;
  logic              wr_en;
  logic              forward;
  logic [SUM_W-1:0]  up;
  logic [SUM_W-1:0]  parent;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  row_max_next;
  logic [STATUS_W-1:0] status_next;
  logic [SUM_W-1:0]  result_next;

  assign out_free = !out_valid || out_ready;
  assign ex_fire  = ex_valid && (!ex_item.last || out_free);
  assign pop      = head_valid && (!ex_valid || ex_fire);
  assign wr_en    = ex_fire && !ex_item.over;

  // The element right below the apex reads the entry written one beat earlier.
  assign forward  = wr_en && (ex_item.col == head_item.col);

  always_comb begin
    up = ex_item.has_up ? rd_data : '0;
    parent = up;
    if (!ex_item.first && (left_parent > parent)) begin
      parent = left_parent;
    end
    sum_wide = {1'b0, parent} + (SUM_W + 1)'(ex_item.value);
    sum = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    row_max_next = (ex_item.first || (sum > row_maximum)) ? sum : row_maximum;

    priority if (ex_item.over) begin
      status_next = ST_TOO_MANY;
    end else if (!ex_item.row_done) begin
      status_next = ST_RAGGED;
    end else begin
      status_next = ST_OK;
    end
    result_next = (status_next == ST_OK) ? row_max_next : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      best_row[ex_item.col] <= sum;
    end
    if (pop) begin
      rd_data <= forward ? sum : best_row[head_item.col];
      ex_item <= head_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid    <= 1'b0;
      left_parent <= '0;
      row_maximum <= '0;
    end else begin
      if (pop) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        if (ex_item.last) begin
          left_parent <= '0;
          row_maximum <= '0;
        end else if (!ex_item.over) begin
          left_parent <= up;
          row_maximum <= row_max_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_fire && ex_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire && ex_item.last) begin
      out_sum    <= result_next;
      out_status <= status_next;
    end
  end

  // An element without a parent above it must be the one that closes its row.
  a_no_up_closes_row: assert property (@(posedge clk) disable iff (rst)
    ex_fire && !ex_item.over && !ex_item.has_up |-> ex_item.row_done)
    else $error("element without an upper parent does not close its row");

  // A failed triangle never reports a nonzero sum.
  a_bad_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != ST_OK) |-> (out_sum == '0))
    else $error("nonzero sum with a failure status");

  // A new result appears only when a closing element has been executed.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(ex_fire && ex_item.last))
    else $error("result appeared without a closing element");

endmodule

`default_nettype wire

[rtl/triangle_max_path_sum.sv]
// Top level of the streaming triangle maximum path sum block.
`default_nettype none

// Elements of a number triangle arrive one beat each in row order (one in
// row 0, two in row 1, and so on), with s_tlast on the final element. The
// block keeps one row of best path sums in a MAX_ROWS-entry buffer and
// updates it top-down, so one element is taken every clock cycle once the
// pipeline is running and no held-off result beat backs it up; the single
// read and write port of the row buffer and the register holding the left
// parent set that rate. An element passes through the front classifier, a
// two-entry queue and an execute stage; the final element registers one
// result beat as it leaves that stage. The beat carries the largest sum of
// the last row in m_tdata and the status in m_tuser: ok, ragged when the
// final row was short (sum zero), or too many rows when more than MAX_ROWS
// rows arrived (sum zero, and this wins over ragged). Path sums saturate at
// the all-ones 24-bit value. After the final element the block is ready for
// the next triangle at once; no clearing pass is needed.
module triangle_max_path_sum (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] value
  input  wire logic        s_tlast,   // last element of the triangle
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [23:0] m_tdata,   // [23:0] max_sum
  output      logic [1:0]  m_tuser    // [1:0] status
);
  import tmps_pkg::*;

  logic       push;
  logic       push_ready;
  tmps_item_t push_item;
  logic       head_valid;
  logic       pop;
  tmps_item_t head_item;

  tmps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_value   (s_tdata),
    .in_last    (s_tlast),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tmps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .head_valid (head_valid),
    .pop        (pop),
    .head_item  (head_item)
  );

  tmps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sum    (m_tdata),
    .out_status (m_tuser)
  );

endmodule

`default_nettype wire

[dv/triangle_max_path_sum_tb.sv]
// Self-checking testbench for the streaming triangle maximum path sum block.
`default_nettype none

// One expected result beat: the best path sum and the status code.
typedef struct packed {
  logic [tmps_pkg::SUM_W-1:0]    max_sum;
  logic [tmps_pkg::STATUS_W-1:0] status;
} path_result_t;

// Tracks the triangle as it streams in and holds the results still owed by the block.
class path_sum_scoreboard;
  logic [tmps_pkg::SUM_W-1:0] best_row [tmps_pkg::MAX_ROWS];
  logic [tmps_pkg::SUM_W-1:0] left_parent;
  logic [tmps_pkg::SUM_W-1:0] row_max;
  int                         row_idx;
  int                         col_idx;
  bit                         overflowed;
  path_result_t               pending [$];
  int                         errors;

  function new();
    errors = 0;
    clear_triangle();
  endfunction

  function void clear_triangle();
    foreach (best_row[i]) best_row[i] = '0;
    left_parent = '0;
    row_max     = '0;
    row_idx     = 0;
    col_idx     = 0;
    overflowed  = 1'b0;
  endfunction

  // Called for every accepted input beat; queues a result when the beat is the last one.
  function void note_beat(logic [tmps_pkg::VALUE_W-1:0] value, logic last);
    logic [tmps_pkg::SUM_W:0]   wide;
    logic [tmps_pkg::SUM_W-1:0] up;
    logic [tmps_pkg::SUM_W-1:0] parent;
    logic [tmps_pkg::SUM_W-1:0] path_sum;
    bit                         row_done;
    path_result_t               res;
    row_done = 1'b0;
    if (!overflowed && row_idx >= tmps_pkg::MAX_ROWS) overflowed = 1'b1;
    if (!overflowed) begin
      up     = '0;
      parent = '0;
      // The entry above-right is only valid when this column existed in the row above.
      if (col_idx < row_idx) begin
        up     = best_row[col_idx];
        parent = up;
      end
      if (col_idx > 0 && left_parent > parent) parent = left_parent;
      wide     = {1'b0, parent} + value;
      path_sum = (wide > tmps_pkg::SUM_MAX) ? tmps_pkg::SUM_MAX : wide[tmps_pkg::SUM_W-1:0];
      left_parent       = up;
      best_row[col_idx] = path_sum;
      if (col_idx == 0 || path_sum > row_max) row_max = path_sum;
      if (col_idx == row_idx) begin
        row_done = 1'b1;
        row_idx  = row_idx + 1;
        col_idx  = 0;
      end else begin
        col_idx = col_idx + 1;
      end
    end
    if (last) begin
      res.max_sum = '0;
      if (overflowed) begin
        res.status = tmps_pkg::ST_TOO_MANY;
      end else if (!row_done) begin
        res.status = tmps_pkg::ST_RAGGED;
      end else begin
        res.status  = tmps_pkg::ST_OK;
        res.max_sum = row_max;
      end
      pending.insert(pending.size(), res);
      clear_triangle();
    end
  endfunction

  // Called for every accepted result beat.
  function void check_result(logic [tmps_pkg::SUM_W-1:0] max_sum,
                             logic [tmps_pkg::STATUS_W-1:0] status);
    path_result_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("result beat with nothing pending: sum %0d status %0d", max_sum, status);
    end else begin
      want = pending.pop_front();
      if (max_sum !== want.max_sum || status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("result beat differs: expected sum %0d status %0d, got sum %0d status %0d",
                   want.max_sum, want.status, max_sum, status);
      end
    end
  endfunction
endclass

module triangle_max_path_sum_tb;

  localparam int IDLE_PCT   = 31;
  localparam int STALL_LEN  = 300;   // receiver hold-off used to back up the pipeline
  localparam int WDOG_LIMIT = 4000;  // cycles with no beat on either side
  localparam int RAND_ITEMS = 850;
  localparam int CALM_ROWS  = 15;
  localparam int CALM_COUNT = CALM_ROWS * (CALM_ROWS + 1) / 2;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  // When calm is set neither side idles; stall_req asks the receiver for one long hold-off.
  bit calm;
  bit stall_req;
  int stall_left;
  int idle_cycles;

  path_sum_scoreboard sb;

  triangle_max_path_sum uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Element values lean on the extremes so that saturation-prone and zero paths both show up.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one element beat. Entered and left at a falling edge; valid is left high so that a
  // following call in the same step simply replaces the data.
  task automatic send_beat(logic [15:0] value, logic last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(value, last);
    @(negedge clk);
  endtask

  // A run of random elements with last on the final one. A row-count sum gives a well-formed
  // triangle; any other count ends the triangle mid-row.
  task automatic send_run(int count);
    for (int i = 0; i < count; i++) send_beat(pick_value(), i == count - 1);
  endtask

  // Sender stops offering until every owed result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random backpressure, one long hold-off on request, none while calm.
  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req  = 1'b0;
        stall_left = STALL_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Result beats are checked at the edge where they are taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Watchdog: ends the run if neither side moves a beat for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("triangle_max_path_sum: mismatch");
    $finish;
  end

  initial begin
    int random_items;
    int pick;
    int rows;
    int count;

    sb        = new();
    calm      = 1'b0;
    stall_req = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Single-element triangles at both value extremes.
    send_beat(16'hFFFF, 1'b1);
    send_beat(16'h0000, 1'b1);
    // Three rows mixing extremes, so the interior element must pick the larger parent.
    send_beat(16'h0000, 1'b0);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h0001, 1'b0);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'hFFFF, 1'b1);
    // Last on the first element of row one: a ragged final row.
    send_beat(16'h0007, 1'b0);
    send_beat(16'h0003, 1'b1);
    // Last in the middle of row two: also ragged.
    send_beat(16'h0001, 1'b0);
    send_beat(16'h0002, 1'b0);
    send_beat(16'h0003, 1'b0);
    send_beat(16'h0004, 1'b0);
    send_beat(16'h0005, 1'b1);
    // Four rows with a strong right edge and a left edge that is weak above the last row.
    send_beat(16'h8000, 1'b0);
    send_beat(16'h0001, 1'b0);
    send_beat(16'h7FFF, 1'b0);
    send_beat(16'h0002, 1'b0);
    send_beat(16'h5555, 1'b0);
    send_beat(16'hAAAA, 1'b0);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h1234, 1'b0);
    send_beat(16'hFFFF, 1'b1);
    drain_results();

    // A deeper triangle streamed back to back on both sides.
    calm = 1'b1;
    send_run(CALM_COUNT);
    calm = 1'b0;
    // Ragged on the deepest row of that triangle.
    send_run(CALM_COUNT - 1);
    drain_results();

    // Hold the receiver off while one-element triangles keep coming, so the block backs up
    // and must stall its input.
    stall_req = 1'b1;
    for (int i = 0; i < 30; i++) send_beat(pick_value(), 1'b1);
    drain_results();

    // Random part: mostly small well-formed triangles, some cut short, some loose noise.
    random_items = 0;
    while (random_items < RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        rows  = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
        count = rows * (rows + 1) / 2;
        send_run(count);
      end else if (pick < 92) begin
        rows  = $urandom_range(1, 10);
        count = rows * (rows + 1) / 2 + $urandom_range(1, rows);
        send_run(count);
      end else begin
        count = $urandom_range(1, 6);
        for (int i = 0; i < count; i++) send_beat(pick_value(), $urandom_range(3) == 0);
      end
      random_items += count;
      if ($urandom_range(19) == 0) drain_results();
    end

    drain_results();
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("triangle_max_path_sum: match");
    end else begin
      $display("triangle_max_path_sum: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/tmps_pkg.sv
rtl/tmps_front.sv
rtl/tmps_queue.sv
rtl/tmps_back.sv
rtl/triangle_max_path_sum.sv
dv/triangle_max_path_sum_tb.sv
